// ===== rtl/core/lss_pkg.sv =====
package lss_pkg;

    // Calibration slots are always 12 bits wide.
    localparam int CAL_SLOT_W = 12;
    localparam int NUM_CH     = 7;
    localparam int SCALED_W   = 7;
    localparam int SUM_W      = 10;
    localparam int ERR_W      = 16;
    localparam int DIV_N_W    = 24;
    localparam int DIV_D_W    = 12;
    localparam int DIV_Q_W    = 15;
    localparam int STEP_W     = 4;
    localparam int CAL_W      = 60;

    // Top quotient bit of a channel scaling divide and of the Q1.14 error divide.
    localparam logic [STEP_W-1:0] CHAN_QUO_TOP = 4'd6;
    localparam logic [STEP_W-1:0] WIDE_QUO_TOP = 4'd14;
    localparam logic [2:0]        CH_LAST      = 3'd6;

    localparam logic [6:0] SCALE_GAIN = 7'd99;
    localparam logic [SCALED_W-1:0] SCALED_MIN = 7'd1;
    localparam logic [SCALED_W-1:0] SCALED_MAX = 7'd100;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CAL_A     = 3'd0;
    localparam logic [2:0] REG_CAL_B     = 3'd1;
    localparam logic [2:0] REG_CAL_C     = 3'd2;
    localparam logic [2:0] REG_GAIN_P    = 3'd3;
    localparam logic [2:0] REG_GAIN_D    = 3'd4;
    localparam logic [2:0] REG_STOP_THR  = 3'd5;
    localparam logic [2:0] REG_SERVO_CTR = 3'd6;

    typedef enum logic [1:0] {
        DIV_CHAN,
        DIV_ERR,
        DIV_MEAN
    } div_src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CH_SETUP,
        ST_CH_DIV,
        ST_CH_STORE,
        ST_ERR_SETUP,
        ST_ERR_DIV,
        ST_ERR_STORE,
        ST_SCAN,
        ST_MEAN_SETUP,
        ST_MEAN_MUL,
        ST_MEAN_STORE,
        ST_PD_MUL,
        ST_PD_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [CAL_W-1:0] cal_a;
        logic [CAL_W-1:0] cal_b;
        logic [CAL_W-1:0] cal_c;
        logic [15:0]      gain_p;
        logic [15:0]      gain_d;
        logic [SUM_W-1:0] stop_thr;
        logic [15:0]      servo_ctr;
    } cfg_t;

    typedef struct packed {
        logic              load_in;
        logic [2:0]        ch;
        logic              ch_store;
        logic              div_load;
        div_src_t          div_src;
        logic              div_step;
        logic [STEP_W-1:0] step;
        logic              err_store;
        logic              scan;
        logic              mean_mul;
        logic              mean_store;
        logic              pd_mul;
        logic              pd_sum;
        logic              out_load;
        logic              steer;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic win_full;
        logic scan_last;
    } sts_t;

endpackage

// ===== rtl/core/lss_ctrl.sv =====
module lss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  lss_pkg::sts_t sts,
    output lss_pkg::cmd_t cmd
);
    import lss_pkg::*;

    state_t            state_reg, state_next;
    logic [2:0]        ch_reg, ch_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              steer_reg, steer_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_reg       <= '0;
            step_reg     <= '0;
            steer_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            step_reg     <= step_next;
            steer_reg    <= steer_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Sequencing of one item through the shared divider and the PD stage.
    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        steer_next = steer_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.step   = step_reg;
        cmd.steer  = steer_reg;
        cmd.div_src = DIV_CHAN;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    ch_next     = '0;
                    state_next  = ST_CH_SETUP;
                end
            end
            ST_CH_SETUP: begin
                if (sts.in_range) begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = DIV_CHAN;
                    step_next    = CHAN_QUO_TOP;
                    state_next   = ST_CH_DIV;
                end else begin
                    state_next = ST_CH_STORE;
                end
            end
            ST_CH_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_CH_STORE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_CH_STORE: begin
                cmd.ch_store = 1'b1;
                if (ch_reg == CH_LAST) begin
                    state_next = ST_ERR_SETUP;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_CH_SETUP;
                end
            end
            ST_ERR_SETUP: begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_ERR;
                step_next    = WIDE_QUO_TOP;
                state_next   = ST_ERR_DIV;
            end
            ST_ERR_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_ERR_STORE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_ERR_STORE: begin
                cmd.err_store = 1'b1;
                steer_next    = sts.win_full;
                state_next    = sts.win_full ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_MEAN_SETUP;
                end
            end
            ST_MEAN_SETUP: begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_MEAN;
                state_next   = ST_MEAN_MUL;
            end
            ST_MEAN_MUL: begin
                cmd.mean_mul = 1'b1;
                state_next   = ST_MEAN_STORE;
            end
            ST_MEAN_STORE: begin
                cmd.mean_store = 1'b1;
                state_next     = ST_PD_MUL;
            end
            ST_PD_MUL: begin
                cmd.pd_mul = 1'b1;
                state_next = ST_PD_SUM;
            end
            ST_PD_SUM: begin
                cmd.pd_sum = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register holds an item until the sink takes it.
    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/core/lss_dpath.sv =====
module lss_dpath #(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [7*SAMPLE_BITS-1:0]       raw_in,
    input  lss_pkg::cfg_t                  cfg,
    input  lss_pkg::cmd_t                  cmd,
    output lss_pkg::sts_t                  sts,
    output logic                           motor_stop,
    output logic                           steer_valid,
    output logic [15:0]                    servo_compare,
    output logic signed [15:0]             filtered_error
);
    import lss_pkg::*;

    localparam int CMP_W  = (SAMPLE_BITS > CAL_SLOT_W) ? SAMPLE_BITS : CAL_SLOT_W;
    localparam int WIDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int ACC_W  = ERR_W + $clog2(WINDOW_LEN + 1);
    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WINDOW_LEN - 1);
    // Reciprocal of the middle count; exact for magnitudes below 2^ACC_W
    // as long as the count is at most 8.
    localparam int MEAN_SHIFT = ACC_W + 3;
    localparam logic [MEAN_SHIFT:0] MEAN_RECIP =
        (MEAN_SHIFT+1)'(((1 << MEAN_SHIFT) + WINDOW_LEN - 3) / (WINDOW_LEN - 2));

    logic [7*SAMPLE_BITS-1:0] raw_reg;
    logic [SCALED_W-1:0]      n_reg [NUM_CH];
    logic [SUM_W-1:0]         sum_reg;
    logic [DIV_N_W-1:0]       rem_reg;
    logic [DIV_D_W-1:0]       den_reg;
    logic [DIV_Q_W-1:0]       quo_reg;
    logic                     neg_reg;
    logic [ACC_W+MEAN_SHIFT:0] mean_prod_reg;
    logic signed [ERR_W-1:0]  win_reg [WINDOW_LEN];
    logic [WIDX_W-1:0]        wcount_reg;
    logic [WIDX_W-1:0]        scan_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ERR_W-1:0]  min_reg, max_reg;
    logic signed [ERR_W-1:0]  f_reg;
    logic signed [ERR_W-1:0]  prev_reg;
    logic signed [32:0]       prod_p_reg;
    logic signed [33:0]       prod_d_reg;
    logic [15:0]              sv_reg;
    logic                     stop_reg;
    logic                     out_stop_reg, out_steer_reg;
    logic [15:0]              out_servo_reg;
    logic signed [ERR_W-1:0]  out_filt_reg;

    // Channel selection and calibration lookup.
    logic [3*CAL_W-1:0]   cal_flat;
    logic [3:0]           slot_lo;
    logic [CAL_SLOT_W-1:0] cal_lo, cal_hi;
    logic [SAMPLE_BITS-1:0] x_raw;
    logic [CMP_W-1:0]     x_w, lo_w, hi_w;
    logic                 x_le, x_ge;
    logic [CAL_SLOT_W-1:0] ch_diff, ch_span;
    logic [18:0]          ch_num;
    logic [SCALED_W-1:0]  n_val;

    assign cal_flat = {cfg.cal_c, cfg.cal_b, cfg.cal_a};
    assign slot_lo  = {cmd.ch, 1'b0};
    assign cal_lo   = cal_flat[CAL_SLOT_W*slot_lo +: CAL_SLOT_W];
    assign cal_hi   = cal_flat[CAL_SLOT_W*slot_lo + CAL_SLOT_W +: CAL_SLOT_W];
    assign x_raw    = raw_reg[SAMPLE_BITS*cmd.ch +: SAMPLE_BITS];
    assign x_w      = CMP_W'(x_raw);
    assign lo_w     = CMP_W'(cal_lo);
    assign hi_w     = CMP_W'(cal_hi);
    assign x_le     = (x_w <= lo_w);
    assign x_ge     = (x_w >= hi_w);
    assign ch_diff  = CAL_SLOT_W'(x_w - lo_w);
    assign ch_span  = cal_hi - cal_lo;
    assign ch_num   = SCALE_GAIN * ch_diff;
    assign n_val    = x_le ? SCALED_MIN :
                      (x_ge ? SCALED_MAX : (quo_reg[SCALED_W-1:0] + 1'b1));

    // Steering error operands from the outer and inner pairs.
    logic signed [8:0] d24, num_s;
    logic [8:0]        abs_d24, abs_num, err_den;

    assign d24     = $signed({2'b00, n_reg[2]}) - $signed({2'b00, n_reg[4]});
    assign num_s   = $signed({2'b00, n_reg[0]}) - $signed({2'b00, n_reg[6]}) + d24;
    assign abs_d24 = d24[8] ? 9'(-d24) : 9'(d24);
    assign abs_num = num_s[8] ? 9'(-num_s) : 9'(num_s);
    assign err_den = 9'(n_reg[0]) + 9'(n_reg[6]) + abs_d24;

    // Middle sum of the window: total less its smallest and largest entry.
    logic signed [ACC_W-1:0] mid_sum;
    logic [ACC_W-1:0]        mid_mag;

    assign mid_sum = acc_reg - ACC_W'(min_reg) - ACC_W'(max_reg);
    assign mid_mag = mid_sum[ACC_W-1] ? ACC_W'(-mid_sum) : ACC_W'(mid_sum);

    // Shared restoring divider, one quotient bit a step.
    logic [DIV_N_W+2:0] div_trial;
    logic               div_fits;
    logic [DIV_N_W-1:0] load_num;
    logic [DIV_D_W-1:0] load_den;
    logic               load_neg;

    assign div_trial = (DIV_N_W+3)'(den_reg) << cmd.step;
    assign div_fits  = ((DIV_N_W+3)'(rem_reg) >= div_trial);

    always_comb begin
        case (cmd.div_src)
            DIV_CHAN: begin
                load_num = DIV_N_W'(ch_num);
                load_den = ch_span;
                load_neg = 1'b0;
            end
            DIV_ERR: begin
                load_num = DIV_N_W'({abs_num, 14'b0});
                load_den = DIV_D_W'(err_den);
                load_neg = num_s[8];
            end
            DIV_MEAN: begin
                load_num = DIV_N_W'(mid_mag);
                load_den = '0;
                load_neg = mid_sum[ACC_W-1];
            end
            default: begin
                load_num = '0;
                load_den = '0;
                load_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= load_num;
            den_reg <= load_den;
            quo_reg <= '0;
            neg_reg <= load_neg;
        end else if (cmd.div_step && div_fits) begin
            rem_reg <= DIV_N_W'((DIV_N_W+3)'(rem_reg) - div_trial);
            quo_reg[cmd.step] <= 1'b1;
        end
    end

    // Mean magnitude by reciprocal multiplication.
    always_ff @(posedge aclk) begin
        if (cmd.mean_mul) begin
            mean_prod_reg <= rem_reg[ACC_W-1:0] * MEAN_RECIP;
        end
    end

    // Signed quotient for the error and the mean.
    logic signed [ERR_W-1:0] quo_s;
    logic [DIV_Q_W-1:0]      mean_quo;
    logic signed [ERR_W-1:0] mean_s;

    assign quo_s    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign mean_quo = mean_prod_reg[MEAN_SHIFT +: DIV_Q_W];
    assign mean_s   = neg_reg ? -$signed({1'b0, mean_quo}) : $signed({1'b0, mean_quo});

    // Scan capture, scaled channels and the stop sum.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            raw_reg <= raw_in;
            sum_reg <= '0;
        end else if (cmd.ch_store) begin
            n_reg[cmd.ch] <= n_val;
            sum_reg       <= sum_reg + SUM_W'(n_val);
        end
    end

    // Error window and its write position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcount_reg <= '0;
        end else if (cmd.err_store) begin
            wcount_reg <= (wcount_reg == WIDX_LAST) ? '0 : wcount_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_store) begin
            win_reg[wcount_reg] <= quo_s;
            stop_reg            <= (sum_reg <= cfg.stop_thr);
        end
    end

    // Pass over the window for total, minimum and maximum.
    always_ff @(posedge aclk) begin
        if (cmd.err_store) begin
            scan_reg <= '0;
        end else if (cmd.scan) begin
            if (scan_reg == '0) begin
                acc_reg <= ACC_W'(win_reg[scan_reg]);
                min_reg <= win_reg[scan_reg];
                max_reg <= win_reg[scan_reg];
            end else begin
                acc_reg <= acc_reg + ACC_W'(win_reg[scan_reg]);
                if (win_reg[scan_reg] < min_reg) begin
                    min_reg <= win_reg[scan_reg];
                end
                if (win_reg[scan_reg] > max_reg) begin
                    max_reg <= win_reg[scan_reg];
                end
            end
            if (scan_reg != WIDX_LAST) begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    // PD products, then rounding, offset and saturation.
    logic signed [16:0] err_delta;
    logic signed [34:0] pd_sum, pd_round;
    logic signed [12:0] pd_term;
    logic signed [17:0] sv_full;

    assign err_delta = 17'(f_reg) - 17'(prev_reg);
    assign pd_sum    = 35'(prod_p_reg) + 35'(prod_d_reg);
    assign pd_round  = pd_sum + 35'sd2097152;
    assign pd_term   = pd_round[34:22];
    assign sv_full   = $signed({2'b00, cfg.servo_ctr}) + 18'(pd_term);

    always_ff @(posedge aclk) begin
        if (cmd.mean_store) begin
            f_reg <= mean_s;
        end
        if (cmd.pd_mul) begin
            prod_p_reg <= $signed({1'b0, cfg.gain_p}) * f_reg;
            prod_d_reg <= $signed({1'b0, cfg.gain_d}) * err_delta;
        end
        if (cmd.pd_sum) begin
            if (sv_full < 0) begin
                sv_reg <= '0;
            end else if (sv_full > 18'sd65535) begin
                sv_reg <= '1;
            end else begin
                sv_reg <= sv_full[15:0];
            end
        end
    end

    // Last trimmed mean; it is state and survives between windows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (cmd.out_load && cmd.steer) begin
            prev_reg <= f_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_stop_reg  <= stop_reg;
            out_steer_reg <= cmd.steer;
            out_servo_reg <= cmd.steer ? sv_reg : '0;
            out_filt_reg  <= cmd.steer ? f_reg : prev_reg;
        end
    end

    assign sts.in_range   = !x_le && !x_ge;
    assign sts.win_full   = (wcount_reg == WIDX_LAST);
    assign sts.scan_last  = (scan_reg == WIDX_LAST);
    assign motor_stop     = out_stop_reg;
    assign steer_valid    = out_steer_reg;
    assign servo_compare  = out_servo_reg;
    assign filtered_error = out_filt_reg;

endmodule

// ===== rtl/core/line_sensor_steering_pd.sv =====
// Channel   Direction  Ports              Contents
// scan      in         s_axis_t*          seven raw samples, channel 0 lowest
// result    out        m_axis_t*          stop flag, servo value, filtered error
// config    in/out     psel..prdata       seven registers at 8-byte spacing
//
// An item is taken only in idle, and the next one only after the output load.
// Each item goes through a setup and store per channel, with a divider pass
// when its sample lies inside the calibrated range, then the Q1.14 error
// divide and the output load. A window-closing item adds the window pass, the
// mean by reciprocal multiply and the PD stage. The channel and error divides
// share one restoring divider that resolves one quotient bit a cycle.
// Reset is synchronous on aresetn; a result waits in the output register
// while the next item is taken in, and only a result still waiting at the
// end of the next item stalls the block.
module line_sensor_steering_pd #(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_ch0 .. raw_ch6, SAMPLE_BITS each, zero padded to whole bytes
    input  logic [((7*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // motor_stop [0], servo_compare [16:1], filtered_error [32:17], zero pad
    output logic [39:0] m_axis_tdata,
    // steer_valid [0]
    output logic [0:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import lss_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        cmd;
    sts_t        sts;
    logic [2:0]  reg_idx;
    logic        cfg_wr;
    logic        motor_stop, steer_valid;
    logic [15:0] servo_compare;
    logic signed [15:0] filtered_error;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cal_a     <= '0;
            cfg_reg.cal_b     <= '0;
            cfg_reg.cal_c     <= '0;
            cfg_reg.gain_p    <= 16'd256;
            cfg_reg.gain_d    <= '0;
            cfg_reg.stop_thr  <= '0;
            cfg_reg.servo_ctr <= 16'd110;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CAL_A:     cfg_reg.cal_a     <= pwdata[CAL_W-1:0];
                REG_CAL_B:     cfg_reg.cal_b     <= pwdata[CAL_W-1:0];
                REG_CAL_C:     cfg_reg.cal_c     <= pwdata[CAL_W-1:0];
                REG_GAIN_P:    cfg_reg.gain_p    <= pwdata[15:0];
                REG_GAIN_D:    cfg_reg.gain_d    <= pwdata[15:0];
                REG_STOP_THR:  cfg_reg.stop_thr  <= pwdata[SUM_W-1:0];
                REG_SERVO_CTR: cfg_reg.servo_ctr <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_idx)
            REG_CAL_A:     prdata = 64'(cfg_reg.cal_a);
            REG_CAL_B:     prdata = 64'(cfg_reg.cal_b);
            REG_CAL_C:     prdata = 64'(cfg_reg.cal_c);
            REG_GAIN_P:    prdata = 64'(cfg_reg.gain_p);
            REG_GAIN_D:    prdata = 64'(cfg_reg.gain_d);
            REG_STOP_THR:  prdata = 64'(cfg_reg.stop_thr);
            REG_SERVO_CTR: prdata = 64'(cfg_reg.servo_ctr);
            default:       prdata = '0;
        endcase
    end

    lss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lss_dpath #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .raw_in         (s_axis_tdata[7*SAMPLE_BITS-1:0]),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .motor_stop     (motor_stop),
        .steer_valid    (steer_valid),
        .servo_compare  (servo_compare),
        .filtered_error (filtered_error)
    );

    assign m_axis_tdata = {7'b0, filtered_error, servo_compare, motor_stop};
    assign m_axis_tuser = steer_valid;

endmodule

// ===== rtl/core/lss_checker.sv =====
module lss_checker #(
    parameter int SAMPLE_BITS = 12
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [((7*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result item keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
    else $error("stalled result item changed");

    // The block is busy for the cycle after it takes a scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("scan taken while the previous one is still in work");

    // Without a new steering value the servo field reads zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[16:1] == 16'd0)
    else $error("servo value given outside a window end");

    // The filtered error stays within plus or minus one in Q1.14.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $signed(m_axis_tdata[32:17]) <= 16'sd16384 &&
                          $signed(m_axis_tdata[32:17]) >= -16'sd16384)
    else $error("filtered error out of range");

endmodule

bind line_sensor_steering_pd lss_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lss_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lss_pkg::*;

    typedef struct {
        logic [11:0] raw [7];
    } scan_t;

    typedef struct {
        logic        stop;
        logic        steer;
        logic [15:0] servo;
        logic [15:0] ferr;
    } steer_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    line_sensor_steering_pd dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state: calibration, gains and the error window.
    logic [59:0] cal_words [3];
    logic [15:0] kp, kd, center;
    logic [9:0]  stop_thr;
    int          err_win [5];
    int          win_fill;
    int          last_mean;

    scan_t      scan_queue [$];
    steer_out_t steer_expected [$];
    int         fail_count = 0;
    int         result_count = 0;
    int         steer_count = 0;
    bit         stim_done = 1'b0;

    function automatic int scaled_level(int ch, int x);
        int lo, hi, slot;
        slot = 2 * ch;
        lo = int'(cal_words[slot / 5][(slot % 5) * 12 +: 12]);
        slot = 2 * ch + 1;
        hi = int'(cal_words[slot / 5][(slot % 5) * 12 +: 12]);
        if (x <= lo) return 1;
        if (x >= hi) return 100;
        return 99 * (x - lo) / (hi - lo) + 1;
    endfunction

    // Compute the result of one scan and advance the window state.
    function automatic steer_out_t steer_predict(scan_t sc);
        steer_out_t r;
        int n [7];
        int sum, num, den, d24, mag, e, tmp, acc, f;
        int srt [5];
        longint p, term, sv;
        sum = 0;
        for (int c = 0; c < 7; c++) begin
            n[c] = scaled_level(c, int'(sc.raw[c]));
            sum += n[c];
        end
        r.stop = (sum <= int'(stop_thr));
        num = (n[0] - n[6]) + (n[2] - n[4]);
        d24 = n[2] - n[4];
        den = n[0] + n[6] + (d24 < 0 ? -d24 : d24);
        mag = (num < 0 ? -num : num) * 16384 / den;
        e = num < 0 ? -mag : mag;
        if (win_fill >= 5) win_fill = 0;
        err_win[win_fill] = e;
        win_fill++;
        r.steer = 1'b0;
        r.servo = '0;
        if (win_fill >= 5) begin
            srt = err_win;
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 4 - i; j++)
                    if (srt[j] > srt[j + 1]) begin
                        tmp = srt[j]; srt[j] = srt[j + 1]; srt[j + 1] = tmp;
                    end
            acc = srt[1] + srt[2] + srt[3];
            f = acc < 0 ? -((-acc) / 3) : acc / 3;
            p = longint'(kp) * f + longint'(kd) * (f - last_mean);
            term = (p + (64'sd1 <<< 21)) >>> 22;
            sv = longint'(center) + term;
            if (sv < 0) sv = 0;
            if (sv > 65535) sv = 65535;
            r.servo = sv[15:0];
            r.steer = 1'b1;
            last_mean = f;
            win_fill = 0;
        end
        r.ferr = last_mean[15:0];
        return r;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CAL_A:     cal_words[0] = val[59:0];
            REG_CAL_B:     cal_words[1] = val[59:0];
            REG_CAL_C:     cal_words[2] = val[59:0];
            REG_GAIN_P:    kp = val[15:0];
            REG_GAIN_D:    kd = val[15:0];
            REG_STOP_THR:  stop_thr = val[9:0];
            REG_SERVO_CTR: center = val[15:0];
            default: ;
        endcase
    endtask

    // Handshakes seen at the rising edge, for the falling-edge processes.
    bit s_fire = 1'b0;
    bit m_fire = 1'b0;
    always @(posedge aclk) begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        m_fire <= m_axis_tvalid && m_axis_tready;
    end

    // Driver: one scan per item, with a random gap before each.
    int tx_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_fire) begin
                s_axis_tvalid <= 1'b0;
                tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            end else if (!s_axis_tvalid && scan_queue.size() > 0) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else begin
                    scan_t sc;
                    sc = scan_queue.pop_front();
                    for (int c = 0; c < 7; c++) s_axis_tdata[c * 12 +: 12] <= sc.raw[c];
                    s_axis_tvalid <= 1'b1;
                    steer_expected.push_back(steer_predict(sc));
                end
            end
        end
    end

    // Receiver stall pattern.
    int rx_gap = 0;
    always @(negedge aclk) begin
        if (m_fire) begin
            rx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            m_axis_tready <= (rx_gap == 0);
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compare each result item with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            steer_out_t e;
            steer_out_t a;
            a.stop = m_axis_tdata[0];
            a.servo = m_axis_tdata[16:1];
            a.ferr = m_axis_tdata[32:17];
            a.steer = m_axis_tuser[0];
            result_count++;
            if (steer_expected.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, m_axis_tdata);
                fail_count++;
            end else begin
                e = steer_expected.pop_front();
                if (a.steer) steer_count++;
                if (a.stop !== e.stop || a.steer !== e.steer || a.servo !== e.servo ||
                    a.ferr !== e.ferr || m_axis_tdata[39:33] !== '0) begin
                    $display("%0t: expected stop=%0d steer=%0d servo=%0d err=%0d, got %0d %0d %0d %0d",
                             $time, e.stop, e.steer, e.servo, $signed(e.ferr),
                             a.stop, a.steer, a.servo, $signed(a.ferr));
                    fail_count++;
                end
            end
        end
    end

    function automatic scan_t rand_scan(int mode);
        scan_t sc;
        for (int c = 0; c < 7; c++) begin
            case (mode)
                0: sc.raw[c] = $urandom_range(0, 4095);
                1: sc.raw[c] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                default: sc.raw[c] = $urandom_range(800, 3300);
            endcase
        end
        return sc;
    endfunction

    task automatic wait_drained();
        while (scan_queue.size() > 0 || steer_expected.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [59:0] rand_cal();
        logic [59:0] w;
        for (int k = 0; k < 5; k++) begin
            int lo;
            lo = $urandom_range(0, 2000);
            w[k * 12 +: 12] = (k % 2 == 0) ? 12'(lo) : 12'($urandom_range(1500, 4095));
        end
        return w;
    endfunction

    initial begin
        scan_t sc;
        cal_words[0] = '0; cal_words[1] = '0; cal_words[2] = '0;
        kp = 16'd256; kd = 16'd0; stop_thr = '0; center = 16'd110;
        err_win = '{default: 0};
        win_fill = 0;
        last_mean = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: zero spans, so samples give only 1 or 100.
        for (int i = 0; i < 10; i++) scan_queue.push_back(rand_scan(1));
        wait_drained();

        // Directed: extremes of calibration, gains and threshold.
        reg_write(REG_CAL_A, {12'd100, 12'd3995, 12'd100, 12'd3995, 12'd100});
        reg_write(REG_CAL_B, {12'd3995, 12'd100, 12'd3995, 12'd100, 12'd3995});
        reg_write(REG_CAL_C, {12'hFFF, 12'd3995, 12'd100, 12'd3995, 12'd100});
        reg_write(REG_GAIN_P, 64'hFFFF);
        reg_write(REG_GAIN_D, 64'hFFFF);
        reg_write(REG_STOP_THR, 64'd700);
        reg_write(REG_SERVO_CTR, 64'd0);
        for (int i = 0; i < 5; i++) begin
            for (int c = 0; c < 7; c++) sc.raw[c] = 12'd0;
            sc.raw[0] = 12'hFFF; sc.raw[2] = 12'd2000;
            scan_queue.push_back(sc);
        end
        for (int i = 0; i < 5; i++) begin
            for (int c = 0; c < 7; c++) sc.raw[c] = 12'd0;
            sc.raw[6] = 12'hFFF; sc.raw[4] = 12'hFFF;
            scan_queue.push_back(sc);
        end
        for (int i = 0; i < 5; i++) scan_queue.push_back(rand_scan(i % 3));
        wait_drained();
        reg_write(REG_SERVO_CTR, 64'hFFFF);
        reg_write(REG_STOP_THR, 64'd0);
        for (int i = 0; i < 5; i++) scan_queue.push_back(rand_scan(0));
        wait_drained();

        // Random phases over several settings.
        for (int ph = 0; ph < 5; ph++) begin
            reg_write(REG_CAL_A, {$urandom, $urandom});
            reg_write(REG_CAL_B, ph == 4 ? 64'hFFFF_FFFF_FFFF_FFFF : {4'd0, rand_cal()});
            reg_write(REG_CAL_C, {4'd0, rand_cal()});
            reg_write(REG_GAIN_P, ph == 0 ? 64'd0 : 64'($urandom_range(0, 65535)));
            reg_write(REG_GAIN_D, 64'($urandom_range(0, 65535)));
            reg_write(REG_STOP_THR, 64'($urandom_range(0, 1023)));
            reg_write(REG_SERVO_CTR, 64'($urandom_range(0, 65535)));
            for (int i = 0; i < 100; i++) scan_queue.push_back(rand_scan($urandom_range(0, 2)));
            wait_drained();
        end
        stim_done = 1'b1;

        $display("Covered %0d result items, %0d servo updates, across eight settings.",
                 result_count, steer_count);
        if (fail_count == 0) begin
            $display("[line_sensor_steering_pd] OK");
        end else begin
            $display("[line_sensor_steering_pd] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d items pending.", steer_expected.size());
        $display("[line_sensor_steering_pd] ERROR");
        $finish;
    end

endmodule
